FILE: sv/pmt_pkg.sv
// Package for the program map section parser: phase encoding, record kinds
// and the result record layout. No dependencies.
`timescale 1ns / 1ps

package pmt_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP_PROG,
    PH_ENTRY,
    PH_SKIP_ES
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Header byte positions of the fields captured after the table id.
  localparam logic [3:0] POS_LEN_HI  = 4'd1;
  localparam logic [3:0] POS_LEN_LO  = 4'd2;
  localparam logic [3:0] POS_PROG_HI = 4'd3;
  localparam logic [3:0] POS_PROG_LO = 4'd4;
  localparam logic [3:0] POS_VERSION = 4'd5;
  localparam logic [3:0] POS_SECT    = 4'd6;
  localparam logic [3:0] POS_LAST    = 4'd7;
  localparam logic [3:0] POS_PCR_HI  = 4'd8;
  localparam logic [3:0] POS_PCR_LO  = 4'd9;
  localparam logic [3:0] POS_INFO_HI = 4'd10;

  // Byte offsets inside one elementary stream entry.
  localparam logic [2:0] EB_TYPE    = 3'd0;
  localparam logic [2:0] EB_PID_HI  = 3'd1;
  localparam logic [2:0] EB_PID_LO  = 3'd2;
  localparam logic [2:0] EB_INFO_HI = 3'd3;

  // Fixed header bytes not counted in the entry loop, and entry size.
  localparam int unsigned HEADER_TAIL = 13;
  localparam int unsigned ENTRY_BYTES = 5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tbl_id;
    logic [11:0] sect_len;
    logic [15:0] prog_num;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [12:0] pid;
    logic [11:0] info_length;
    logic [7:0]  stream_type;
    logic        last;
  } pmt_rec_t;

endpackage

FILE: sv/pmt_section_parser.sv
// Top level of the program map section parser: byte parse logic feeding a
// buffered record output. Depends on pmt_pkg, pmt_parse and pmt_outbuf.
//
//   port group  dir  tdata                 tuser        tlast
//   s_*         in   data_byte             first        -
//   m_*         out  record fields (96b)   kind         last
//
// One byte per cycle while s_tready is high: each transfer updates counters
// and captured fields in the same cycle, and its record (if any) lands in the
// output register on that edge, or in the skid stage while the sink stalls.
// Records: one header or error record on header byte 11, one per stream entry
// on its fifth byte. Reset (rst, synchronous) idles the parser until a byte
// flagged as first. s_tready drops only while the skid stage holds a record
// that m_tready has not yet drained.
`timescale 1ns / 1ps

module pmt_section_parser #(
  parameter int LENGTH_LIMIT = 1021
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // first
  output logic        m_tvalid,
  input  logic        m_tready,
  // tbl_id[7:0], sect_len[19:8], prog_num[35:20],
  // version[40:36], current_next[41], sect_num[49:42],
  // last_sect_num[57:50], pid[70:58], info_length[82:71],
  // stream_type[90:83], zero fill[95:91]
  output logic [95:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);
  import pmt_pkg::*;

  logic     in_xfer;
  logic     rec_valid;
  pmt_rec_t rec;
  pmt_rec_t out_rec;

  // Advance the parser only on a completed input transfer.
  assign in_xfer = s_tvalid && s_tready;

  pmt_parse #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .data_byte (s_tdata),
    .first     (s_tuser),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Hold finished records while the sink stalls.
  pmt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rec_valid),
    .in_rec    (rec),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec)
  );

  assign m_tdata = {5'b0,
                    out_rec.stream_type,
                    out_rec.info_length,
                    out_rec.pid,
                    out_rec.last_sect_num,
                    out_rec.sect_num,
                    out_rec.current_next,
                    out_rec.version,
                    out_rec.prog_num,
                    out_rec.sect_len,
                    out_rec.tbl_id};
  assign m_tuser = out_rec.kind;
  assign m_tlast = out_rec.last;

endmodule

FILE: sv/pmt_parse.sv
// Byte-wise parse logic: phase, counters and captured fields; produces at most
// one record per accepted byte. Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_parse #(
  parameter int LENGTH_LIMIT = 1021
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        data_byte,
  input  logic              first,
  output logic              rec_valid,
  output pmt_pkg::pmt_rec_t rec
);
  import pmt_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [2:0]  entry_byte, entry_byte_next;
  logic [11:0] skip_count, skip_count_next;
  logic signed [13:0] entries_left, entries_left_next;

  logic [7:0]  tbl_id, tbl_id_next;
  logic [11:0] sect_len, sect_len_next;
  logic [15:0] prog_num, prog_num_next;
  logic [4:0]  version, version_next;
  logic        current_next, current_next_next;
  logic [7:0]  sect_num, sect_num_next;
  logic [7:0]  last_sect_num, last_sect_num_next;
  logic [12:0] pcr_pid, pcr_pid_next;
  logic [3:0]  info_hi, info_hi_next;

  logic [7:0]  es_type, es_type_next;
  logic [12:0] es_pid, es_pid_next;
  logic [3:0]  es_info_hi, es_info_hi_next;

  logic [11:0] prog_info;
  logic [11:0] es_info;
  logic signed [14:0] rem_init, rem_entry;
  logic        done;

  assign prog_info = {info_hi, data_byte};
  assign es_info   = {es_info_hi, data_byte};
  assign rem_init  = 15'(sect_len) - 15'(HEADER_TAIL) - 15'(prog_info);
  assign rem_entry = 15'(entries_left) - 15'(ENTRY_BYTES) - 15'(es_info);
  assign done      = rem_entry[14] || (rem_entry == '0);

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    entry_byte_next     = entry_byte;
    skip_count_next     = skip_count;
    entries_left_next   = entries_left;
    tbl_id_next         = tbl_id;
    sect_len_next       = sect_len;
    prog_num_next       = prog_num;
    version_next        = version;
    current_next_next   = current_next;
    sect_num_next       = sect_num;
    last_sect_num_next  = last_sect_num;
    pcr_pid_next        = pcr_pid;
    info_hi_next        = info_hi;
    es_type_next        = es_type;
    es_pid_next         = es_pid;
    es_info_hi_next     = es_info_hi;

    if (first) begin
      tbl_id_next        = data_byte;
      byte_position_next = POS_LEN_HI;
      phase_next         = PH_HEADER;
      entry_byte_next    = EB_TYPE;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          byte_position_next = byte_position + 4'd1;
          unique case (byte_position)
            POS_LEN_HI:  sect_len_next[11:8] = data_byte[3:0];
            POS_LEN_LO:  sect_len_next[7:0]  = data_byte;
            POS_PROG_HI: prog_num_next[15:8] = data_byte;
            POS_PROG_LO: prog_num_next[7:0]  = data_byte;
            POS_VERSION: begin
              version_next      = data_byte[5:1];
              current_next_next = data_byte[0];
            end
            POS_SECT:    sect_num_next        = data_byte;
            POS_LAST:    last_sect_num_next   = data_byte;
            POS_PCR_HI:  pcr_pid_next[12:8]   = data_byte[4:0];
            POS_PCR_LO:  pcr_pid_next[7:0]    = data_byte;
            POS_INFO_HI: info_hi_next         = data_byte[3:0];
            default: begin
              // Last header byte: length check, then descriptors or entries.
              if (sect_len > 12'(LENGTH_LIMIT)) begin
                phase_next = PH_IDLE;
              end else begin
                entries_left_next = 14'(rem_init);
                skip_count_next   = prog_info;
                entry_byte_next   = EB_TYPE;
                phase_next        = (prog_info != '0) ? PH_SKIP_PROG : PH_ENTRY;
              end
            end
          endcase
        end
        PH_SKIP_PROG, PH_SKIP_ES: begin
          skip_count_next = skip_count - 12'd1;
          if (skip_count == 12'd1) begin
            phase_next = PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          entry_byte_next = entry_byte + 3'd1;
          unique case (entry_byte)
            EB_TYPE:    es_type_next        = data_byte;
            EB_PID_HI:  es_pid_next[12:8]   = data_byte[4:0];
            EB_PID_LO:  es_pid_next[7:0]    = data_byte;
            EB_INFO_HI: es_info_hi_next     = data_byte[3:0];
            default: begin
              entry_byte_next = EB_TYPE;
              if (done) begin
                entries_left_next = '0;
                phase_next        = PH_IDLE;
              end else begin
                entries_left_next = 14'(rem_entry);
                if (es_info != '0) begin
                  skip_count_next = es_info;
                  phase_next      = PH_SKIP_ES;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Record for the current byte; header fields are complete when it fires.
  always_comb begin
    rec_valid          = 1'b0;
    rec.kind           = KIND_HEADER;
    rec.tbl_id         = tbl_id;
    rec.sect_len       = sect_len;
    rec.prog_num       = prog_num;
    rec.version        = version;
    rec.current_next   = current_next;
    rec.sect_num       = sect_num;
    rec.last_sect_num  = last_sect_num;
    rec.pid            = pcr_pid;
    rec.info_length    = prog_info;
    rec.stream_type    = '0;
    rec.last           = 1'b0;
    if (in_valid && !first) begin
      if (phase == PH_HEADER && byte_position > POS_INFO_HI) begin
        rec_valid = 1'b1;
        if (sect_len > 12'(LENGTH_LIMIT)) begin
          rec.kind = KIND_ERROR;
          rec.last = 1'b1;
        end
      end else if (phase == PH_ENTRY && entry_byte > EB_INFO_HI) begin
        rec_valid       = 1'b1;
        rec.kind        = KIND_ENTRY;
        rec.pid         = es_pid;
        rec.info_length = es_info;
        rec.stream_type = es_type;
        rec.last        = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      entry_byte    <= '0;
      skip_count    <= '0;
      entries_left  <= '0;
    end else if (in_valid) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      entry_byte    <= entry_byte_next;
      skip_count    <= skip_count_next;
      entries_left  <= entries_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      tbl_id        <= tbl_id_next;
      sect_len      <= sect_len_next;
      prog_num      <= prog_num_next;
      version       <= version_next;
      current_next  <= current_next_next;
      sect_num      <= sect_num_next;
      last_sect_num <= last_sect_num_next;
      pcr_pid       <= pcr_pid_next;
      info_hi       <= info_hi_next;
      es_type       <= es_type_next;
      es_pid        <= es_pid_next;
      es_info_hi    <= es_info_hi_next;
    end
  end

endmodule

FILE: sv/pmt_outbuf.sv
// Output register with a skid stage for result records.
// Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pmt_pkg::pmt_rec_t in_rec,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pmt_pkg::pmt_rec_t out_rec
);
  import pmt_pkg::*;

  logic     skid_valid;
  pmt_rec_t skid_rec;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_rec <= skid_valid ? skid_rec : in_rec;
    end else if (in_valid && !skid_valid) begin
      skid_rec <= in_rec;
    end
  end

endmodule
